// ----- rtl/hps_pkg.sv -----
// Shared widths and register indexes for the height profile smoothing block.
// No dependencies.
package hps_pkg;
  localparam int SAMPLE_W = 16;
  localparam int RADIUS_W = 5;
  localparam int DBAND_W  = 15;
  localparam int CFG_W    = 15;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_DBAND  = 1'b1
  } cfg_reg_t;
endpackage

// ----- rtl/hps_cell.sv -----
// One sample cell of the ring row: holds a sample, passes it on when enabled.
// Depends on hps_pkg.
module hps_cell (
  input  logic                                 clk,
  input  logic                                 shift_en,
  input  logic signed [hps_pkg::SAMPLE_W-1:0]  d_in,
  output logic signed [hps_pkg::SAMPLE_W-1:0]  q
);
  import hps_pkg::*;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d_in;
    end
  end
endmodule

// ----- rtl/hps_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module hps_divider #(
  parameter int NW = 26,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    den;
  logic [CNT_W-1:0] bits_left;
  logic             busy;
  logic [DW:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem, quotient[NW-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        bits_left <= CNT_W'(NW);
        quotient  <= dividend;
        den       <= divisor;
        rem       <= '0;
      end else if (busy) begin
        rem       <= fits ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
        quotient  <= {quotient[NW-2:0], fits};
        bits_left <= bits_left - 1'b1;
        if (bits_left == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/height_profile_smoothing.sv -----
// Height profile smoothing: dead-band blend of each sample with its window mean over a row of sample cells.
// Depends on hps_pkg, hps_cell, hps_divider.
// Sequential: a word is taken only in idle; a sample that releases no result returns to idle after the check.
// Each result: check, a scan of all RING_DEPTH cells, evaluate and decide, plus the divider when
// blended, then held valid until taken before the next check or the return to idle.
// Synchronous reset clears the profile count and pending index and sets the radius / dead band registers to 10 / 11.
module height_profile_smoothing #(
  parameter int MAX_RADIUS = 31,
  parameter int RING_DEPTH = 64,
  parameter int MAX_LENGTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // height_sample
  input  logic                          s_axis_tlast,  // final_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // smoothed_height
  output logic                          m_axis_tlast,  // final_result
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [hps_pkg::CFG_W-1:0]     cfg_data
);
  import hps_pkg::*;

  localparam int CW    = $clog2(MAX_LENGTH + 1);
  localparam int IW    = CW + 2;
  localparam int STW   = $clog2(RING_DEPTH);
  localparam int CNTW  = $clog2(2 * MAX_RADIUS + 1);
  localparam int SUMW  = SAMPLE_W + CNTW;
  localparam int PW    = SAMPLE_W + CNTW + 1;
  localparam int NW    = PW + 3;
  localparam int DENW  = CNTW + 3;
  localparam int THRW  = DBAND_W + CNTW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SCAN, ST_EVAL, ST_DECIDE, ST_DIV, ST_OUT
  } state_t;

  state_t                       state;
  logic [CW-1:0]                count;
  logic [CW-1:0]                emit;
  logic                         last_flag;
  logic                         is_end;
  logic [RADIUS_W-1:0]          radius;
  logic [DBAND_W-1:0]           dband;
  logic signed [IW-1:0]         wstart;
  logic signed [IW-1:0]         wend;
  logic [STW-1:0]               step;
  logic signed [SUMW-1:0]       sum;
  logic signed [SAMPLE_W-1:0]   y;
  logic signed [PW-1:0]         prod;
  logic [THRW-1:0]              thr;
  logic [DENW-1:0]              den;
  logic                         neg;
  logic [SAMPLE_W-1:0]          result;
  logic                         div_start;
  logic [NW-1:0]                div_num;
  logic                         div_done;
  logic [NW-1:0]                div_q;

  logic signed [SAMPLE_W-1:0]   cell_q [RING_DEPTH];
  logic                         shift_en;
  logic                         accept;
  logic [RADIUS_W-1:0]          r_eff;
  logic [CW:0]                  count_inc;
  logic signed [IW-1:0]         i_s, n_s, r_s, ws_next, we_next, scan_idx;
  logic signed [IW-1:0]         cnt_s;
  logic [CNTW-1:0]              cnt;
  logic signed [PW:0]           dev;
  logic [PW:0]                  abs_dev;
  logic signed [NW-1:0]         num;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = result;
  assign m_axis_tlast  = is_end;
  assign shift_en      = accept || (state == ST_SCAN);

  for (genvar k = 0; k < RING_DEPTH; k++) begin : g_row
    logic signed [SAMPLE_W-1:0] d;
    if (k == 0) begin : g_head
      assign d = accept ? $signed(s_axis_tdata) : cell_q[RING_DEPTH-1];
    end else begin : g_body
      assign d = cell_q[k-1];
    end
    hps_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(d), .q(cell_q[k]));
  end

  assign r_eff     = (radius == '0) ? RADIUS_W'(1) :
                     ((radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius);
  assign count_inc = {1'b0, count} + 1'b1;
  assign i_s       = $signed({2'b00, emit});
  assign n_s       = $signed({2'b00, count});
  assign r_s       = $signed(IW'(r_eff));
  assign scan_idx  = n_s - IW'(RING_DEPTH) + $signed(IW'(step));

  always_comb begin
    if (i_s < r_s) begin
      ws_next = '0;
      we_next = r_s + i_s;
    end else if (i_s + r_s > n_s) begin
      ws_next = n_s - r_s;
      we_next = n_s;
    end else begin
      ws_next = i_s - r_s;
      we_next = i_s + r_s;
    end
    if (ws_next < 0) ws_next = '0;
    if (we_next > n_s) we_next = n_s;
  end

  assign cnt_s   = wend - wstart;
  assign cnt     = cnt_s[CNTW-1:0];
  assign dev     = PW'(prod) - PW'(sum) ;
  assign abs_dev = dev[PW] ? (PW+1)'(-dev) : dev;
  assign num     = (NW'(prod) <<< 2) + NW'(sum);

  hps_divider #(.NW(NW), .DW(DENW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(den), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      emit      <= '0;
      last_flag <= 1'b0;
      is_end    <= 1'b0;
      radius    <= RADIUS_W'(10);
      dband     <= DBAND_W'(11);
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_RADIUS: radius <= cfg_data[RADIUS_W-1:0];
          REG_DBAND:  dband  <= cfg_data[DBAND_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count     <= count_inc[CW-1:0];
            last_flag <= s_axis_tlast || (count_inc >= (CW+1)'(MAX_LENGTH));
            state     <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          wstart <= ws_next;
          wend   <= we_next;
          step   <= '0;
          sum    <= '0;
          is_end <= last_flag && ({1'b0, emit} + 1'b1 == {1'b0, count});
          if (last_flag ? (emit < count)
                        : ({1'b0, emit} + (CW+1)'(r_eff) <= {1'b0, count})) begin
            state <= ST_SCAN;
          end else begin
            if (last_flag) begin
              count     <= '0;
              emit      <= '0;
              last_flag <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_idx >= wstart && scan_idx < wend) begin
            sum <= sum + SUMW'(cell_q[RING_DEPTH-1]);
          end
          if (scan_idx == i_s) y <= cell_q[RING_DEPTH-1];
          step <= step + 1'b1;
          if (step == STW'(RING_DEPTH - 1)) state <= ST_EVAL;
        end
        ST_EVAL: begin
          prod  <= y * $signed({1'b0, cnt});
          thr   <= dband * cnt;
          den   <= DENW'(cnt) * DENW'(5);
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (is_end || !(abs_dev > (PW+1)'(thr))) begin
            result <= y;
            state  <= ST_OUT;
          end else begin
            neg       <= num[NW-1];
            div_num   <= num[NW-1] ? NW'(-num + NW'(den) - 1) : num;
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            result <= neg ? SAMPLE_W'(-div_q) : div_q[SAMPLE_W-1:0];
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            emit  <= emit + 1'b1;
            state <= ST_CHECK;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- verif/tb.sv -----
// Testbench for height_profile_smoothing: streams height profiles and checks every
// smoothed word against a dead-band smoothing predictor kept inside the bench.
// Depends on hps_pkg and the height_profile_smoothing RTL.
module tb;
  import hps_pkg::*;

  localparam int RING    = 64;
  localparam int MAXLEN  = 4096;
  localparam int MAXRES  = 31;
  localparam int SETTLE  = 300;
  localparam int WD_MAX  = 20000;

  typedef struct packed {
    logic signed [15:0] height;
    logic               fin;
  } smooth_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // height_sample
  logic              s_axis_tlast = 1'b0; // final_sample
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // smoothed_height
  logic              m_axis_tlast;        // final_result
  logic              cfg_we = 1'b0;
  logic              cfg_addr = REG_RADIUS;
  logic [CFG_W-1:0]  cfg_data = '0;

  height_profile_smoothing u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] hist [RING];
  int                 n_seen;
  int                 next_out;
  logic [4:0]         radius;
  logic [14:0]        dband;
  smooth_word_t       pending_q[$];

  int src_idle, snk_idle;
  int n_in, n_profiles;
  int n_out = 0;
  int n_err = 0;
  int wd = 0;

  function automatic longint hist_at(int idx);
    return longint'(hist[idx % RING]);
  endfunction

  function automatic logic signed [15:0] smooth_at(int i, int n, int r);
    longint lo, hi, sum, cnt, y, dev, num, den, q;
    sum = 0;
    if (i < r) begin
      lo = 0; hi = r + i;
    end else if (i + r > n) begin
      lo = n - r; hi = n;
    end else begin
      lo = i - r; hi = i + r;
    end
    if (lo < 0) lo = 0;
    if (hi > n) hi = n;
    for (longint j = lo; j < hi; j++) sum += hist_at(int'(j));
    cnt = hi - lo;
    y = hist_at(i);
    if (cnt <= 0) return y[15:0];
    dev = y * cnt - sum;
    if (dev < 0) dev = -dev;
    if (dev <= longint'(dband) * cnt) return y[15:0];
    num = 4 * y * cnt + sum;
    den = 5 * cnt;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return q[15:0];
  endfunction

  function automatic void predict(logic signed [15:0] h, logic fin);
    int r, k;
    logic last;
    smooth_word_t w;
    r = (radius == 0) ? 1 : int'(radius);
    k = 0;
    hist[n_seen % RING] = h;
    n_seen++;
    last = fin || (n_seen >= MAXLEN);
    if (last) begin
      while (next_out < n_seen && k < MAXRES) begin
        w.fin = (next_out + 1 == n_seen);
        w.height = w.fin ? hist[next_out % RING] : smooth_at(next_out, n_seen, r);
        pending_q = {pending_q, w};
        k++; next_out++;
      end
      n_seen = 0; next_out = 0; n_profiles++;
    end else begin
      while (next_out + r <= n_seen && k < MAXRES) begin
        w.fin = 1'b0;
        w.height = smooth_at(next_out, n_seen, r);
        pending_q = {pending_q, w};
        k++; next_out++;
      end
    end
  endfunction

  task automatic send_sample(logic signed [15:0] h, logic fin);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    s_axis_tlast  <= fin;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    predict(h, fin);
    n_in++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == REG_RADIUS) radius = val[4:0];
    else dband = val[14:0];
  endtask

  task automatic test_extremes;
    write_reg(REG_RADIUS, 15'd1);
    write_reg(REG_DBAND, 15'd0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b1);
    write_reg(REG_DBAND, 15'h7FFF);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
  endtask

  task automatic test_short_profiles;
    write_reg(REG_RADIUS, 15'd10);
    write_reg(REG_DBAND, 15'd3);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd400, 1'b0);
    send_sample(16'sd900, 1'b1);
    send_sample(16'sh1234, 1'b1);   // single sample
    write_reg(REG_RADIUS, 15'h7FE0); // radius field zero, upper bits junk
    send_sample(16'sd50, 1'b0);
    send_sample(-16'sd50, 1'b0);
    send_sample(16'sd500, 1'b1);
  endtask

  task automatic test_radius_change;
    write_reg(REG_RADIUS, 15'd5);
    write_reg(REG_DBAND, 15'd2);
    for (int i = 0; i < 8; i++) send_sample(16'($urandom_range(0, 2000)) - 16'sd1000, 1'b0);
    write_reg(REG_RADIUS, 15'd31);
    for (int i = 0; i < 5; i++) send_sample(16'($urandom), 1'b0);
    write_reg(REG_RADIUS, 15'd2);
    send_sample(16'sd7, 1'b1);
  endtask

  task automatic test_random(int n_items);
    int left, len, base;
    logic signed [15:0] h;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(2) == 0)
        write_reg(REG_RADIUS, 15'($urandom_range(0, 31)));
      if ($urandom_range(2) == 0)
        write_reg(REG_DBAND, ($urandom_range(4) == 0) ? 15'($urandom) : 15'($urandom_range(64)));
      len  = ($urandom_range(5) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 30);
      base = $urandom_range(0, 40000) - 20000;
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0: h = 16'($urandom);
          1: h = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          default: h = 16'(base + $urandom_range(0, 200) - 100);
        endcase
        send_sample(h, i == len - 1);
      end
      left -= len;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  // sampled mid-cycle: the values seen here are the ones taken at the next rising edge
  always @(negedge clk) begin
    smooth_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected word: height %0d last %0b", $signed(m_axis_tdata), m_axis_tlast);
      end else begin
        want = pending_q.pop_front();
        if (want.height !== m_axis_tdata || want.fin !== m_axis_tlast) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: expected %0d/%0b got %0d/%0b", want.height, want.fin,
                     $signed(m_axis_tdata), m_axis_tlast);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      wd <= 0;
    end else begin
      wd <= wd + 1;
      if (wd >= WD_MAX) begin
        $display("watchdog: no traffic for %0d cycles", WD_MAX);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    n_seen = 0; next_out = 0; radius = 5'd10; dband = 15'd11;
    n_in = 0; n_profiles = 0;
    src_idle = 26; snk_idle = 79;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_short_profiles();
    test_radius_change();
    test_random(130);
    src_idle = 79; snk_idle = 26;
    test_random(130);
    src_idle = 0; snk_idle = 0;
    test_random(120);
    drain();
    $display("sent %0d samples in %0d profiles, checked %0d smoothed words", n_in, n_profiles,
             n_out);
    $display("radius 0..31, dead band 0..32767, short, single-sample and mid-profile radius");
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/hps_pkg.sv
rtl/hps_cell.sv
rtl/hps_divider.sv
rtl/height_profile_smoothing.sv
verif/tb.sv
